>>> hdl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 7;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSHED    = 2'd0,
        ST_POPPED    = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] prio;
    } spq_entry_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        spq_entry_t item;
    } spq_ctl_t;

endpackage

>>> hdl/sorted_priority_queue.sv
// Sorted priority queue top level: request handshake, count, capacity register, cell row.
//
// On each request (push or pop), all cells act together: the queue is a row of DEPTH
// cells kept in descending priority order, and every cell compares its own priority with
// the pushed one and shifts toward the tail on a push or toward the head on a pop, all in
// the same clock edge. One request is taken per cycle while in_stall is low, and its result
// appears in the output register on the next cycle. Equal priorities leave newest first.
// A push when the count has reached min(capacity, DEPTH) reports overflow; a pop on an
// empty queue reports underflow; neither changes the contents. The capacity register sits
// at byte address 0 of the APB port and resets to 64.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     func,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic signed [DATA_W-1:0] item_priority,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] popped_value
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           status_reg;
    status_t           status_next;
    logic [DATA_W-1:0] popped_reg;
    logic [DATA_W-1:0] popped_next;

    logic              accept;
    logic              full;
    logic              empty;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  limit;
    spq_ctl_t          ctl;

    logic       [DEPTH-1:0] keep;
    logic       [DEPTH-1:0] occupied;
    spq_entry_t [DEPTH-1:0] entries;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-CAP_W){1'b0}}, capacity_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(64);
        end
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign cap_ext = CMP_W'(capacity_reg);
    assign limit   = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign full    = CMP_W'(count_reg) >= limit;
    assign empty   = (count_reg == '0);

    always_comb
    begin
        ctl.push       = accept && (func == FUNC_PUSH) && !full;
        ctl.pop        = accept && (func == FUNC_POP) && !empty;
        ctl.item.value = item_value;
        ctl.item.prio  = item_priority;
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        popped_next    = popped_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            popped_next    = '0;
            if (func == FUNC_PUSH)
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    status_next = ST_PUSHED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    status_next = ST_POPPED;
                    popped_next = entries[0].value;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign occupied[i] = CNT_W'(i) < count_reg;

        spq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occupied   (occupied[i]),
            .prev_keep  ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
            .prev_entry ((i == 0) ? ctl.item : entries[(i == 0) ? 0 : i - 1]),
            .next_entry ((i == DEPTH - 1) ? ctl.item : entries[(i == DEPTH - 1) ? i : i + 1]),
            .keep       (keep[i]),
            .entry      (entries[i])
        );
    end

endmodule

>>> hdl/spq_cell.sv
// One storage cell of the sorted shift array.
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  spq_ctl_t   ctl,
    input  logic       occupied,
    input  logic       prev_keep,
    input  spq_entry_t prev_entry,
    input  spq_entry_t next_entry,
    output logic       keep,
    output spq_entry_t entry
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    assign keep  = occupied && ($signed(entry_reg.prio) > $signed(ctl.item.prio));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push)
        begin
            if (keep)
            begin
                entry_next = entry_reg;
            end
            else if (prev_keep)
            begin
                entry_next = ctl.item;
            end
            else
            begin
                entry_next = prev_entry;
            end
        end
        else if (ctl.pop)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> dv/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted priority queue: ordering, capacity limits and handshake stalls.
module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int DEPTH = 64;
    localparam logic [2:0] CAPACITY_ADDR = 3'd0;

    typedef struct {
        status_t           status;
        logic [DATA_W-1:0] popped_value;
    } outcome_t;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [2:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_stall;
    logic                     func;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped_value;

    spq_entry_t shadow_queue[$];
    logic [CAP_W-1:0] shadow_capacity = 7'd64;
    outcome_t expected_outcomes[$];
    int err_count = 0;
    int tx_calm = 0;
    int rx_hold = 0;
    int rx_calm = 0;

    sorted_priority_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .item_value(item_value),
        .item_priority(item_priority),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .popped_value(popped_value)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function outcome_t apply_queue_op(input logic op, input logic [DATA_W-1:0] val,
                                      input logic [DATA_W-1:0] pri);
        outcome_t   res;
        spq_entry_t ent;
        int         loc;
        int         limit;
        res.status = ST_PUSHED;
        res.popped_value = '0;
        limit = (int'(shadow_capacity) > DEPTH) ? DEPTH : int'(shadow_capacity);
        if (op == FUNC_PUSH)
        begin
            if (shadow_queue.size() >= limit)
            begin
                res.status = ST_OVERFLOW;
            end
            else
            begin
                loc = 0;
                while (loc < shadow_queue.size() &&
                       $signed(shadow_queue[loc].prio) > $signed(pri))
                begin
                    loc++;
                end
                ent.value = val;
                ent.prio = pri;
                shadow_queue.insert(loc, ent);
            end
        end
        else if (shadow_queue.size() == 0)
        begin
            res.status = ST_UNDERFLOW;
        end
        else
        begin
            res.status = ST_POPPED;
            res.popped_value = shadow_queue[0].value;
            void'(shadow_queue.pop_front());
        end
        return res;
    endfunction

    always @(posedge clk)
    begin : result_monitor
        outcome_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_outcomes.push_back(apply_queue_op(func, item_value, item_priority));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("unexpected result: status %0d, popped_value %0d",
                           status, popped_value);
                    err_count++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        err_count++;
                    end
                    if (popped_value !== want.popped_value)
                    begin
                        $error("popped_value: expected %0d, actual %0d",
                               $signed(want.popped_value), popped_value);
                        err_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_stall <= 1'b1;
                rx_hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (rx_calm > 0)
                begin
                    rx_calm--;
                end
                else if ($urandom_range(0, 99) < 25)
                begin
                    rx_hold = pick_gap();
                end
                else if ($urandom_range(0, 99) < 3)
                begin
                    rx_calm = $urandom_range(20, 80);
                end
            end
        end
    end

    task send_request(input logic op, input logic [DATA_W-1:0] val,
                      input logic [DATA_W-1:0] pri);
        int gap;
        int roll;
        begin
            gap = 0;
            if (tx_calm > 0)
            begin
                tx_calm--;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                begin
                    tx_calm = $urandom_range(20, 60);
                end
                else if (roll >= 55)
                begin
                    gap = pick_gap();
                end
            end
            @(negedge clk);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            func <= op;
            item_value <= val;
            item_priority <= pri;
            do @(posedge clk); while (in_stall);
        end
    endtask

    task settle_queue();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (expected_outcomes.size() != 0) @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task write_capacity(input logic [CAP_W-1:0] cap);
        begin
            @(negedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= CAPACITY_ADDR;
            pwdata <= {{(32 - CAP_W){1'b0}}, cap};
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            shadow_capacity = cap;
            @(negedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
    endtask

    task test_empty_pop();
        begin
            send_request(FUNC_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        end
    endtask

    task test_priority_order();
        int n;
        begin
            send_request(FUNC_PUSH, 32'h7FFF_FFFF, 32'h0000_0000);
            send_request(FUNC_PUSH, 32'h8000_0000, 32'h7FFF_FFFF);
            send_request(FUNC_PUSH, 32'hFFFF_FFFF, 32'h8000_0000);
            send_request(FUNC_PUSH, 32'h0000_0000, 32'h0000_0000);
            send_request(FUNC_PUSH, 32'h1234_5678, 32'hFFFF_FFFF);
            send_request(FUNC_PUSH, 32'hA5A5_A5A5, 32'h7FFF_FFFF);
            for (n = 0; n < 7; n++)
            begin
                send_request(FUNC_POP, $urandom, $urandom);
            end
        end
    endtask

    task test_capacity_lowered();
        int n;
        begin
            for (n = 0; n < 4; n++)
            begin
                send_request(FUNC_PUSH, $urandom, $urandom_range(0, 3));
            end
            settle_queue();
            write_capacity(7'd2);
            send_request(FUNC_PUSH, $urandom, $urandom);
            send_request(FUNC_POP, $urandom, $urandom);
            send_request(FUNC_PUSH, $urandom, $urandom);
            send_request(FUNC_POP, $urandom, $urandom);
            send_request(FUNC_POP, $urandom, $urandom);
            send_request(FUNC_PUSH, $urandom, $urandom);
            send_request(FUNC_PUSH, $urandom, $urandom);
        end
    endtask

    task run_mixed_phase(input logic [CAP_W-1:0] cap, input int count, input int push_pct);
        int n;
        int sel;
        logic op;
        logic [DATA_W-1:0] pri;
        begin
            settle_queue();
            write_capacity(cap);
            for (n = 0; n < count; n++)
            begin
                op = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
                sel = $urandom_range(0, 9);
                if (sel < 5)
                begin
                    pri = $urandom_range(0, 7) - 4;
                end
                else if (sel < 7)
                begin
                    pri = (sel == 5) ? 32'h7FFF_FFFF : 32'h8000_0000;
                end
                else
                begin
                    pri = $urandom;
                end
                send_request(op, $urandom, pri);
            end
        end
    endtask

    task test_random_traffic();
        begin
            run_mixed_phase(7'd1, 40, 50);
            run_mixed_phase(7'd0, 20, 50);
            run_mixed_phase(7'd127, 150, 85);
            run_mixed_phase(7'd5, 60, 30);
            run_mixed_phase(7'd65, 120, 25);
            run_mixed_phase(7'd64, 150, 80);
            run_mixed_phase(7'd100, 60, 15);
            run_mixed_phase(7'd2, 50, 50);
            run_mixed_phase(7'd17, 100, 60);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        func = FUNC_PUSH;
        item_value = '0;
        item_priority = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_pop();
        test_priority_order();
        test_capacity_lowered();
        test_random_traffic();
        settle_queue();

        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
